@@ design/fcsl_pkg.sv @@
package fcsl_pkg;

    // Field widths fixed by the face format
    localparam int COORD_W   = 16;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int GAIN_W    = COORD_W - 1;
    localparam int GAIN_SQ_W = 2 * GAIN_W;
    localparam int LEVEL_W   = 4;
    localparam int CAND_SQ_W = 2 * LEVEL_W;
    localparam int SCALED_W  = CAND_SQ_W + COORD_W;

    // Default depth of the queue between classifier and shader
    localparam int QUEUE_DEPTH = 4;

    // APB register map (word index)
    localparam logic [1:0] REG_CAMERA_X = 2'd0;
    localparam logic [1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [1:0] REG_CAMERA_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec3_t;

    typedef struct packed {
        vec3_t normal;
        vec3_t vertex;
    } face_t;

    // Word carried from classifier to shader
    typedef struct packed {
        logic              visible;
        logic [GAIN_W-1:0] gain;
        logic [COORD_W-1:0] scale;
    } shade_word_t;

    // One stage of the level search
    typedef struct packed {
        logic                 visible;
        logic [GAIN_SQ_W-1:0] gain_sq;
        logic [COORD_W-1:0]   scale;
        logic [LEVEL_W-1:0]   level;
    } search_t;

endpackage

@@ design/face_cull_and_shade_level_core.sv @@
// Channel | Ports                         | Word
// --------+-------------------------------+------------------------------------------
// config  | psel penable pwrite paddr ... | camera_x/y/z at byte 0x0/0x4/0x8
// input   | s_valid s_ready s_*           | normal_x/y/z, vertex_x/y/z (signed 16)
// result  | m_valid m_ready m_*           | visible (1), level (4)
//
// One face per cycle while the result side takes words; each face passes
// 9 registers on its way to the result (3 classifier stages, 1 queue entry,
// 5 shader stages), the first loaded at the accepting edge.
// The rate is set by the pipelined multipliers in both halves, one word a stage.
// Reset clears all valid flags, the queue and the camera registers.
// A stalled result holds the shader; the queue lets the classifier keep
// taking faces until it fills.
module face_cull_and_shade_level_core #(
    parameter int QUEUE_DEPTH = fcsl_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [fcsl_pkg::COORD_W-1:0] s_normal_x,
    input  logic signed [fcsl_pkg::COORD_W-1:0] s_normal_y,
    input  logic signed [fcsl_pkg::COORD_W-1:0] s_normal_z,
    input  logic signed [fcsl_pkg::COORD_W-1:0] s_vertex_x,
    input  logic signed [fcsl_pkg::COORD_W-1:0] s_vertex_y,
    input  logic signed [fcsl_pkg::COORD_W-1:0] s_vertex_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_visible,
    output logic [fcsl_pkg::LEVEL_W-1:0]        m_level
);

    fcsl_pkg::vec3_t      camera_reg;
    fcsl_pkg::face_t      face;
    fcsl_pkg::shade_word_t front_word, back_word;
    logic                 front_valid, front_ready, back_valid, back_ready;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Write camera registers; other indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                fcsl_pkg::REG_CAMERA_X: camera_reg.x <= pwdata[fcsl_pkg::COORD_W-1:0];
                fcsl_pkg::REG_CAMERA_Y: camera_reg.y <= pwdata[fcsl_pkg::COORD_W-1:0];
                fcsl_pkg::REG_CAMERA_Z: camera_reg.z <= pwdata[fcsl_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            fcsl_pkg::REG_CAMERA_X: prdata = {16'h0, camera_reg.x};
            fcsl_pkg::REG_CAMERA_Y: prdata = {16'h0, camera_reg.y};
            fcsl_pkg::REG_CAMERA_Z: prdata = {16'h0, camera_reg.z};
            default:                prdata = '0;
        endcase
    end

    always_comb begin
        face.normal.x = s_normal_x;
        face.normal.y = s_normal_y;
        face.normal.z = s_normal_z;
        face.vertex.x = s_vertex_x;
        face.vertex.y = s_vertex_y;
        face.vertex.z = s_vertex_z;
    end

    fcsl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .camera    (camera_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .face      (face),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_word  (front_word)
    );

    fcsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_word   (front_word),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_word  (back_word)
    );

    fcsl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (back_valid),
        .in_ready    (back_ready),
        .in_word     (back_word),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_visible (m_visible),
        .out_level   (m_level)
    );

endmodule

@@ design/fcsl_front.sv @@
module fcsl_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fcsl_pkg::vec3_t      camera,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fcsl_pkg::face_t      face,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fcsl_pkg::shade_word_t out_word
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    fcsl_pkg::vec3_t normal_reg, view_reg;
    fcsl_pkg::vec3_t view_next;

    logic signed [fcsl_pkg::PROD_W-1:0] dot_x_reg, dot_y_reg, dot_z_reg;
    logic signed [fcsl_pkg::PROD_W-1:0] dot_x_next, dot_y_next, dot_z_next;
    logic [fcsl_pkg::PROD_W-1:0]        sq_x_reg, sq_y_reg, sq_z_reg;
    logic signed [fcsl_pkg::PROD_W-1:0] sq_x_next, sq_y_next, sq_z_next;

    logic [fcsl_pkg::PROD_W-1:0] dot_sum, sq_sum;
    fcsl_pkg::shade_word_t       word_reg, word_next;

    // Stall chain: a stage loads when it is empty or its word moves on
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // View vector, wrapped to 16 bits
    always_comb begin
        view_next.x = camera.x - face.vertex.x;
        view_next.y = camera.y - face.vertex.y;
        view_next.z = camera.z - face.vertex.z;
    end

    // Products of normal and view, and view squares
    always_comb begin
        dot_x_next = normal_reg.x * view_reg.x;
        dot_y_next = normal_reg.y * view_reg.y;
        dot_z_next = normal_reg.z * view_reg.z;
        sq_x_next  = view_reg.x * view_reg.x;
        sq_y_next  = view_reg.y * view_reg.y;
        sq_z_next  = view_reg.z * view_reg.z;
    end

    // Sum, classify and keep the upper halves
    always_comb begin
        dot_sum = dot_x_reg + dot_y_reg + dot_z_reg;
        sq_sum  = sq_x_reg + sq_y_reg + sq_z_reg;
        word_next.visible = !dot_sum[fcsl_pkg::PROD_W-1];
        word_next.gain    = dot_sum[fcsl_pkg::PROD_W-2:fcsl_pkg::COORD_W];
        word_next.scale   = sq_sum[fcsl_pkg::PROD_W-1:fcsl_pkg::COORD_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            normal_reg <= face.normal;
            view_reg   <= view_next;
        end
        if (rdy2 && v1_reg) begin
            dot_x_reg <= dot_x_next;
            dot_y_reg <= dot_y_next;
            dot_z_reg <= dot_z_next;
            sq_x_reg  <= sq_x_next;
            sq_y_reg  <= sq_y_next;
            sq_z_reg  <= sq_z_next;
        end
        if (rdy3 && v2_reg) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_word  = word_reg;

endmodule

@@ design/fcsl_queue.sv @@
module fcsl_queue #(
    parameter int DEPTH = fcsl_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fcsl_pkg::shade_word_t in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fcsl_pkg::shade_word_t out_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    fcsl_pkg::shade_word_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic push, pop;

    assign in_ready  = (count_reg != FULL);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_word  = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

@@ design/fcsl_back.sv @@
module fcsl_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fcsl_pkg::shade_word_t         in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_visible,
    output logic [fcsl_pkg::LEVEL_W-1:0]  out_level
);

    // Stage 0 squares the gain, stages 1..LEVEL_W settle one level bit each
    localparam int NSTAGE = fcsl_pkg::LEVEL_W + 1;
    localparam int LW     = fcsl_pkg::LEVEL_W;

    logic                 valid_reg [NSTAGE];
    fcsl_pkg::search_t    stage_reg [NSTAGE];
    fcsl_pkg::search_t    stage_next [NSTAGE];
    logic                 rdy [NSTAGE+1];

    logic [LW-1:0]                    cand     [NSTAGE];
    logic [fcsl_pkg::CAND_SQ_W-1:0]   cand_sq  [NSTAGE];
    logic [fcsl_pkg::SCALED_W-1:0]    scaled   [NSTAGE];

    // Stall chain from the result side back to the queue
    always_comb begin
        rdy[NSTAGE] = out_ready;
        for (int i = NSTAGE - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end
    assign in_ready = rdy[0];

    always_comb begin
        // Square the gain; start the search at level 0
        stage_next[0].visible = in_word.visible;
        stage_next[0].gain_sq = {{fcsl_pkg::GAIN_W{1'b0}}, in_word.gain}
                                * {{fcsl_pkg::GAIN_W{1'b0}}, in_word.gain};
        stage_next[0].scale   = in_word.scale;
        stage_next[0].level   = '0;
        cand[0]    = '0;
        cand_sq[0] = '0;
        scaled[0]  = '0;

        // Keep a level bit when level^2 * scale stays within gain^2;
        // this equals floor(sqrt(gain^2 / scale)) capped at the top level
        for (int i = 1; i < NSTAGE; i++) begin
            cand[i]    = stage_reg[i-1].level | (LW'(1) << (LW - i));
            cand_sq[i] = {{LW{1'b0}}, cand[i]} * {{LW{1'b0}}, cand[i]};
            scaled[i]  = {{fcsl_pkg::COORD_W{1'b0}}, cand_sq[i]}
                         * {{fcsl_pkg::CAND_SQ_W{1'b0}}, stage_reg[i-1].scale};
            stage_next[i] = stage_reg[i-1];
            if ({{(fcsl_pkg::GAIN_SQ_W - fcsl_pkg::SCALED_W){1'b0}}, scaled[i]}
                    <= stage_reg[i-1].gain_sq) begin
                stage_next[i].level = cand[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTAGE; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            stage_reg[0] <= stage_next[0];
        end
        for (int i = 1; i < NSTAGE; i++) begin
            if (rdy[i] && valid_reg[i-1]) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // Culled faces show level 0
    assign out_valid   = valid_reg[NSTAGE-1];
    assign out_visible = stage_reg[NSTAGE-1].visible;
    assign out_level   = stage_reg[NSTAGE-1].visible ? stage_reg[NSTAGE-1].level : '0;

endmodule

@@ design/fcsl_checker.sv @@
module fcsl_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_visible,
    input logic [fcsl_pkg::LEVEL_W-1:0] m_level
);

    // Culled faces carry level 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |-> m_level == '0)
        else $error("culled face with nonzero level");

    // Reset empties the result side
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Reset leaves the input side open
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // Stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_visible) && $stable(m_level))
        else $error("stalled result word changed");

endmodule

bind face_cull_and_shade_level_core fcsl_checker u_fcsl_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_visible (m_visible),
    .m_level   (m_level)
);

@@ verif/tb_face_cull_and_shade_level_core.sv @@
`timescale 1ns / 1ps

module tb_face_cull_and_shade_level_core;

    localparam int COORD_W = fcsl_pkg::COORD_W;
    localparam int LEVEL_W = fcsl_pkg::LEVEL_W;

    typedef fcsl_pkg::face_t face_t;

    // Index past the last camera register; writes there must be dropped
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic               visible;
        logic [LEVEL_W-1:0] level;
    } shade_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_normal_x = '0;
    logic signed [COORD_W-1:0] s_normal_y = '0;
    logic signed [COORD_W-1:0] s_normal_z = '0;
    logic signed [COORD_W-1:0] s_vertex_x = '0;
    logic signed [COORD_W-1:0] s_vertex_y = '0;
    logic signed [COORD_W-1:0] s_vertex_z = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_visible;
    logic [LEVEL_W-1:0]        m_level;

    // Camera position as last written over the register port
    logic signed [COORD_W-1:0] cam_x = '0;
    logic signed [COORD_W-1:0] cam_y = '0;
    logic signed [COORD_W-1:0] cam_z = '0;

    face_t  face_q[$];
    shade_t shade_q[$];

    int   src_idle_pct = 7;
    int   sink_idle_pct = 66;
    int   mismatches = 0;
    int   quiet_cycles = 0;
    logic in_fire = 1'b0;

    face_cull_and_shade_level_core DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_normal_x (s_normal_x),
        .s_normal_y (s_normal_y),
        .s_normal_z (s_normal_z),
        .s_vertex_x (s_vertex_x),
        .s_vertex_y (s_vertex_y),
        .s_vertex_z (s_vertex_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_visible  (m_visible),
        .m_level    (m_level)
    );

    always #5 aclk = ~aclk;

    // Predict visibility and brightness level of one face
    function automatic shade_t shade_face(face_t f);
        logic signed [COORD_W-1:0] view_x, view_y, view_z;
        logic signed [31:0]        dot;
        logic [31:0]               len_sq;
        logic [31:0]               gain_sq;
        logic [31:0]               ratio;
        logic [15:0]               gain;
        logic [15:0]               scale;
        shade_t                    r;
        view_x = cam_x - $signed(f.vertex.x);
        view_y = cam_y - $signed(f.vertex.y);
        view_z = cam_z - $signed(f.vertex.z);
        dot = $signed(f.normal.x) * view_x + $signed(f.normal.y) * view_y
            + $signed(f.normal.z) * view_z;
        r.visible = ~dot[31];
        r.level = '0;
        if (!dot[31]) begin
            len_sq = view_x * view_x + view_y * view_y + view_z * view_z;
            gain = dot[31:16];
            scale = len_sq[31:16];
            if (scale == 0) begin
                r.level = 4'd15;
            end else begin
                gain_sq = gain * gain;
                ratio = gain_sq / scale;
                if (ratio >= 256) begin
                    r.level = 4'd15;
                end else begin
                    for (int k = 1; k <= 15; k++)
                        if (k * k <= ratio) r.level = k[LEVEL_W-1:0];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Random coordinate of random magnitude
    function automatic logic signed [COORD_W-1:0] spread_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        return v >>> $urandom_range(15, 0);
    endfunction

    function automatic logic signed [COORD_W-1:0] corner_coord();
        case ($urandom_range(4, 0))
            0: return 16'sh8000;
            1: return 16'shffff;
            2: return 16'sh0000;
            3: return 16'sh0001;
            default: return 16'sh7fff;
        endcase
    endfunction

    task automatic push_face(int nx, int ny, int nz, int vx, int vy, int vz);
        face_t f;
        f.normal = {COORD_W'(nx), COORD_W'(ny), COORD_W'(nz)};
        f.vertex = {COORD_W'(vx), COORD_W'(vy), COORD_W'(vz)};
        face_q.push_back(f);
    endtask

    // Mix fully random faces, faces aimed near the current camera and corner-value faces
    task automatic push_random_faces(int count);
        face_t f;
        int    pick;
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if (pick < 30) begin
                f = {$urandom, $urandom, $urandom};
            end else if (pick < 80) begin
                f.normal = {spread_coord(), spread_coord(), spread_coord()};
                f.vertex.x = cam_x - spread_coord();
                f.vertex.y = cam_y - spread_coord();
                f.vertex.z = cam_z - spread_coord();
            end else if (pick < 90) begin
                f.normal = {spread_coord(), spread_coord(), spread_coord()};
                f.vertex.x = cam_x + COORD_W'($urandom_range(2, 0)) - 16'sd1;
                f.vertex.y = cam_y + COORD_W'($urandom_range(2, 0)) - 16'sd1;
                f.vertex.z = cam_z + COORD_W'($urandom_range(2, 0)) - 16'sd1;
            end else begin
                f.normal = {corner_coord(), corner_coord(), corner_coord()};
                f.vertex = {corner_coord(), corner_coord(), corner_coord()};
            end
            face_q.push_back(f);
        end
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_camera_reg(logic [1:0] idx, logic [COORD_W-1:0] value);
        logic [31:0] want_rd;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fcsl_pkg::REG_CAMERA_X: cam_x = value;
            fcsl_pkg::REG_CAMERA_Y: cam_y = value;
            fcsl_pkg::REG_CAMERA_Z: cam_z = value;
            default: ;
        endcase
        // Read back the register just written
        want_rd = (idx == REG_SPARE) ? 32'h0 : {16'h0, value};
        if (prdata !== want_rd)
            report_mismatch($sformatf("read back %h at index %0d, expected %h",
                                      prdata, idx, want_rd));
    endtask

    task automatic set_camera(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z);
        write_camera_reg(fcsl_pkg::REG_CAMERA_X, x);
        write_camera_reg(fcsl_pkg::REG_CAMERA_Y, y);
        write_camera_reg(fcsl_pkg::REG_CAMERA_Z, z);
        write_camera_reg(REG_SPARE, 16'($urandom));
    endtask

    // Hold until every queued face has gone in and every result has come out
    task automatic wait_idle();
        do begin
            @(negedge aclk);
            #1;
        end while (face_q.size() != 0 || s_valid || shade_q.size() != 0);
        repeat (12) @(negedge aclk);
    endtask

    // Face driver: present the next face once the current word is taken
    always @(negedge aclk) begin : face_driver
        face_t f;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (face_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                f = face_q.pop_front();
                s_valid <= 1'b1;
                s_normal_x <= f.normal.x;
                s_normal_y <= f.normal.y;
                s_normal_z <= f.normal.z;
                s_vertex_x <= f.vertex.x;
                s_vertex_y <= f.vertex.y;
                s_vertex_z <= f.vertex.z;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result backpressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end

    // Monitor: predict on input words, check result words in order
    always @(posedge aclk) begin : shade_monitor
        face_t  seen;
        shade_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                seen.normal = {s_normal_x, s_normal_y, s_normal_z};
                seen.vertex = {s_vertex_x, s_vertex_y, s_vertex_z};
                shade_q.push_back(shade_face(seen));
            end
            if (m_valid && m_ready) begin
                if (shade_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result visible=%0b level=%0d",
                                              m_visible, m_level));
                end else begin
                    want = shade_q.pop_front();
                    if (m_visible !== want.visible)
                        report_mismatch($sformatf("visible %0b, expected %0b",
                                                  m_visible, want.visible));
                    if (m_level !== want.level)
                        report_mismatch($sformatf("level %0d, expected %0d",
                                                  m_level, want.level));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Abort when no word moves for too long
    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[face_cull_and_shade_level_core] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed faces at reset camera (origin): the view vector is minus the vertex
        src_idle_pct = 7;
        sink_idle_pct = 66;
        write_camera_reg(REG_SPARE, 16'h7abc);
        push_face(0, 0, 0, 0, 0, 0);
        push_face(32767, 32767, 32767, -32768, -32768, -32768);
        // dot product overflow: all three products positive, sum wraps negative
        push_face(-32768, -32768, -32768, -32768, -32768, -32768);
        push_face(-32768, -32768, 0, -32768, -32768, 0);
        push_face(32767, 32767, 32767, -32767, -32767, -32767);
        push_face(-32768, 0, 0, -32768, 0, 0);
        push_face(0, -32768, 0, 0, -32768, 0);
        push_face(0, 0, 32767, 0, 0, -32767);
        // ratio right at 225, and just below it
        push_face(3840, 0, 0, -4096, 0, 0);
        push_face(3824, 0, 0, -4096, 0, 0);
        push_face(2048, 0, 0, -4096, 0, 0);
        push_face(256, 0, 0, -4096, 0, 0);
        push_face(255, 0, 0, -4096, 0, 0);
        // short view vector: scale is zero
        push_face(1, 1, 1, -1, -1, -1);
        push_face(-1, 0, 0, -1, 0, 0);
        push_face(0, 0, 0, 32767, -32768, 32767);
        push_face(-1024, 0, 0, 32767, 32767, 32767);
        push_face(0, 0, 2048, 0, 0, -2048);
        push_face(3000, -2000, 1000, -1000, 500, -300);
        push_face(-1, -1, -1, 1, 1, 1);
        wait_idle();

        set_camera(16'h8000, 16'h7fff, 16'h8000);
        push_random_faces(280);
        wait_idle();

        src_idle_pct = 66;
        sink_idle_pct = 7;
        set_camera(16'h7fff, 16'h8000, 16'h7fff);
        push_random_faces(280);
        wait_idle();

        set_camera(16'($urandom), 16'($urandom), 16'($urandom));
        push_random_faces(270);
        wait_idle();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        set_camera(16'h0000, 16'h0000, 16'h0000);
        push_random_faces(270);
        wait_idle();

        if (mismatches == 0 && shade_q.size() == 0) begin
            $display("[face_cull_and_shade_level_core] OK");
        end else begin
            $display("[face_cull_and_shade_level_core] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/fcsl_pkg.sv
design/fcsl_front.sv
design/fcsl_queue.sv
design/fcsl_back.sv
design/face_cull_and_shade_level_core.sv
design/fcsl_checker.sv
verif/tb_face_cull_and_shade_level_core.sv
